[hdl/kmbx_pkg.sv]
// Shared command codes, status codes and slot record type for the keyed mailbox.
package kmbx_pkg;

  // Command codes carried on s_tuser
  localparam logic [2:0] CMD_SET_EPOCH = 3'd0;
  localparam logic [2:0] CMD_LOAD_WORD = 3'd1;
  localparam logic [2:0] CMD_PUT       = 3'd2;
  localparam logic [2:0] CMD_TAKE      = 3'd3;
  localparam logic [2:0] CMD_PURGE     = 3'd4;

  // Result status codes
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_INVALID_SIZE = 3'd1;
  localparam logic [2:0] ST_FULL         = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND    = 3'd3;
  localparam logic [2:0] ST_EXPIRED      = 3'd4;

  localparam logic [31:0] TTL_RESET = 32'd300;
  localparam logic [4:0]  COUNT_MAX = 5'd31;

  // One slot record in the metadata memory
  typedef struct packed {
    logic [47:0] key;
    logic [63:0] expiry;
    logic [7:0]  length;
  } meta_t;

endpackage

[hdl/keyed_mailbox_with_expiry.sv]
// Keyed mailbox: put, take and purge over a slot table with expiry epochs.
// set_epoch and load_word go straight to the result; put, take and purge scan all ENTRIES slots
//   through the metadata memory; a stored put then copies PAYLOAD_WORDS staging words.
// A take with payload gives its words one at a time, each read after the last is taken.
// One command at a time; next command accepted once the last result is taken.
// Reset (rst, synchronous): all slots free, staging zero, epoch 0, ttl 300.
module keyed_mailbox_with_expiry
  import kmbx_pkg::*;
#(
  parameter int ENTRIES       = 16,
  parameter int PAYLOAD_WORDS = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         ttl_we,
  input  logic [31:0]  ttl_wdata,
  input  logic         s_tvalid,
  output logic         s_tready,
  // s_tdata: mac[47:0], word_index[50:48], data_word[114:51],
  //          put_len[122:115], epoch_value[186:123], zero fill
  input  logic [191:0] s_tdata,
  // s_tuser: cmd[2:0]
  input  logic [2:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // m_tdata: status[2:0], out_word[66:3], out_len[73:67],
  //          purged_count[78:74], zero fill
  output logic [79:0]  m_tdata,
  output logic         m_tlast
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int KW = (PAYLOAD_WORDS > 1) ? $clog2(PAYLOAD_WORDS) : 1;
  localparam int PD = ENTRIES * PAYLOAD_WORDS;
  localparam int AW = (PD > 1) ? $clog2(PD) : 1;
  localparam int MW = $bits(meta_t);

  localparam logic [IW-1:0] LAST_SLOT = IW'(ENTRIES - 1);
  localparam logic [KW-1:0] LAST_WORD = KW'(PAYLOAD_WORDS - 1);
  localparam logic [9:0]    CAP_BYTES = 10'(PAYLOAD_WORDS * 8);
  localparam logic [6:0]    PW_COUNT  = 7'(PAYLOAD_WORDS);

  // State codes
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_COPY   = 3'd3;
  localparam logic [2:0] S_TRD    = 3'd4;
  localparam logic [2:0] S_TWAIT  = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  logic [2:0]  state;
  logic [31:0] ttl;
  logic [63:0] epoch;

  logic [ENTRIES-1:0]       used;
  logic [PAYLOAD_WORDS-1:0] stg_vld;

  // Latched command
  logic [2:0]  cmd_r;
  logic [47:0] mac_r;
  logic [7:0]  plen_r;
  logic [63:0] epv_r;

  // Scan pipeline
  logic [IW-1:0] scan_idx;
  logic          issue_on;
  logic          chk_vld;
  logic [IW-1:0] chk_idx;
  logic          match_f;
  logic [IW-1:0] match_idx;
  logic          free_f;
  logic [IW-1:0] free_idx;
  logic [63:0]   m_exp;
  logic [7:0]    m_len;
  logic [4:0]    cnt;

  // Copy and stream
  logic [AW-1:0] pbase;
  logic [KW-1:0] copy_rd;
  logic          copy_on;
  logic          wr_vld;
  logic [KW-1:0] wr_idx;
  logic [KW-1:0] rd_k;
  logic [7:0]    rem;

  // Output register
  logic        out_valid;
  logic [2:0]  o_status;
  logic [63:0] o_word;
  logic [6:0]  o_len;
  logic [4:0]  o_cnt;
  logic        o_last;

  // Input fields
  logic [47:0] in_mac;
  logic [2:0]  in_widx;
  logic [63:0] in_data;
  logic [7:0]  in_plen;
  logic [63:0] in_epv;
  logic        put_big;
  assign in_mac  = s_tdata[47:0];
  assign in_widx = s_tdata[50:48];
  assign in_data = s_tdata[114:51];
  assign in_plen = s_tdata[122:115];
  assign in_epv  = s_tdata[186:123];
  assign put_big = {2'd0, in_plen} > CAP_BYTES;

  logic s_acc;
  logic m_acc;
  assign s_tready = (state == S_IDLE) && !out_valid;
  assign s_acc    = s_tvalid && s_tready;
  assign m_acc    = m_tvalid && m_tready;

  assign m_tvalid = out_valid;
  assign m_tlast  = o_last;
  assign m_tdata  = {1'b0, o_cnt, o_len, o_word, o_status};

  // Memory ports
  meta_t         meta_q;
  meta_t         meta_wd;
  logic          meta_we;
  logic [IW-1:0] put_slot;
  logic [MW-1:0] meta_rdata;

  logic          stg_we;
  logic [KW-1:0] stg_waddr;
  logic [63:0]   stg_q;
  logic          widx_ok;

  logic          pay_we;
  logic [AW-1:0] pay_waddr;
  logic [63:0]   pay_wdata;
  logic [AW-1:0] pay_raddr;
  logic [63:0]   pay_q;

  logic [63:0] word_mask;
  logic        chk_used;
  logic        chk_hit;

  assign meta_q    = meta_t'(meta_rdata);
  assign put_slot  = match_f ? match_idx : free_idx;
  assign meta_we   = (state == S_DECIDE) && (cmd_r == CMD_PUT) && (match_f || free_f);
  assign meta_wd   = '{key: mac_r, expiry: epoch + {32'd0, ttl}, length: plen_r};

  assign widx_ok   = {4'd0, in_widx} < PW_COUNT;
  assign stg_waddr = KW'(in_widx);
  assign stg_we    = s_acc && (s_tuser == CMD_LOAD_WORD) && widx_ok;

  assign pay_we    = (state == S_COPY) && wr_vld;
  assign pay_waddr = pbase + AW'(wr_idx);
  assign pay_wdata = stg_vld[wr_idx] ? stg_q : 64'd0;
  assign pay_raddr = pbase + AW'(rd_k);

  assign chk_used  = used[chk_idx];
  assign chk_hit   = chk_used && (meta_q.key == mac_r);
  assign word_mask = (rem < 8'd8) ? ((64'd1 << {rem[2:0], 3'b000}) - 64'd1) : '1;

  kmbx_ram #(.WIDTH(MW), .DEPTH(ENTRIES)) u_meta_ram (
    .clk(clk), .we(meta_we), .waddr(put_slot), .wdata(MW'(meta_wd)),
    .raddr(scan_idx), .rdata(meta_rdata)
  );

  kmbx_ram #(.WIDTH(64), .DEPTH(PAYLOAD_WORDS)) u_stage_ram (
    .clk(clk), .we(stg_we), .waddr(stg_waddr), .wdata(in_data),
    .raddr(copy_rd), .rdata(stg_q)
  );

  kmbx_ram #(.WIDTH(64), .DEPTH(PD)) u_payload_ram (
    .clk(clk), .we(pay_we), .waddr(pay_waddr), .wdata(pay_wdata),
    .raddr(pay_raddr), .rdata(pay_q)
  );

  // Hold the ttl register
  always_ff @(posedge clk) begin
    if (rst) begin
      ttl <= TTL_RESET;
    end else if (ttl_we) begin
      ttl <= ttl_wdata;
    end
  end

  // Command sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      used      <= '0;
      stg_vld   <= '0;
      epoch     <= '0;
      issue_on  <= 1'b0;
      chk_vld   <= 1'b0;
      copy_on   <= 1'b0;
      wr_vld    <= 1'b0;
      match_f   <= 1'b0;
      free_f    <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_acc) begin
            cmd_r    <= s_tuser;
            mac_r    <= in_mac;
            plen_r   <= in_plen;
            epv_r    <= in_epv;
            o_status <= (s_tuser == CMD_PUT && put_big) ? ST_INVALID_SIZE : ST_OK;
            o_word   <= '0;
            o_len    <= '0;
            o_cnt    <= '0;
            o_last   <= 1'b1;
            scan_idx <= '0;
            issue_on <= 1'b1;
            chk_vld  <= 1'b0;
            match_f  <= 1'b0;
            free_f   <= 1'b0;
            cnt      <= '0;
            case (s_tuser)
              CMD_SET_EPOCH: begin
                epoch     <= in_epv;
                out_valid <= 1'b1;
                state     <= S_OUT;
              end
              CMD_LOAD_WORD: begin
                if (widx_ok) begin
                  stg_vld[stg_waddr] <= 1'b1;
                end
                out_valid <= 1'b1;
                state     <= S_OUT;
              end
              CMD_PUT: begin
                if (put_big) begin
                  out_valid <= 1'b1;
                  state     <= S_OUT;
                end else begin
                  state <= S_SCAN;
                end
              end
              CMD_TAKE, CMD_PURGE: begin
                state <= S_SCAN;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end

        S_SCAN: begin
          // Issue one metadata read per cycle
          chk_vld <= issue_on;
          chk_idx <= scan_idx;
          if (issue_on) begin
            if (scan_idx == LAST_SLOT) begin
              issue_on <= 1'b0;
            end else begin
              scan_idx <= scan_idx + 1'b1;
            end
          end
          // Check the entry read last cycle
          if (chk_vld) begin
            if (chk_hit && !match_f) begin
              match_f   <= 1'b1;
              match_idx <= chk_idx;
              m_exp     <= meta_q.expiry;
              m_len     <= meta_q.length;
            end
            if (!chk_used && !free_f) begin
              free_f   <= 1'b1;
              free_idx <= chk_idx;
            end
            if (cmd_r == CMD_PURGE && chk_used && meta_q.expiry < epv_r) begin
              used[chk_idx] <= 1'b0;
              if (cnt != COUNT_MAX) begin
                cnt <= cnt + 1'b1;
              end
            end
            if (chk_idx == LAST_SLOT) begin
              state <= S_DECIDE;
            end
          end
        end

        S_DECIDE: begin
          case (cmd_r)
            CMD_PUT: begin
              if (!match_f && !free_f) begin
                o_status  <= ST_FULL;
                out_valid <= 1'b1;
                state     <= S_OUT;
              end else begin
                used[put_slot] <= 1'b1;
                pbase   <= AW'(put_slot) * AW'(PAYLOAD_WORDS);
                copy_rd <= '0;
                copy_on <= 1'b1;
                wr_vld  <= 1'b0;
                state   <= S_COPY;
              end
            end
            CMD_TAKE: begin
              if (!match_f) begin
                o_status  <= ST_NOT_FOUND;
                out_valid <= 1'b1;
                state     <= S_OUT;
              end else begin
                used[match_idx] <= 1'b0;
                if (epoch != 64'd0 && m_exp < epoch) begin
                  o_status  <= ST_EXPIRED;
                  out_valid <= 1'b1;
                  state     <= S_OUT;
                end else if (m_len == 8'd0) begin
                  out_valid <= 1'b1;
                  state     <= S_OUT;
                end else begin
                  pbase <= AW'(match_idx) * AW'(PAYLOAD_WORDS);
                  rd_k  <= '0;
                  rem   <= m_len;
                  state <= S_TRD;
                end
              end
            end
            default: begin
              // Purge reports its count
              o_cnt     <= cnt;
              out_valid <= 1'b1;
              state     <= S_OUT;
            end
          endcase
        end

        S_COPY: begin
          // Read staging word, write it to the slot next cycle
          wr_vld <= copy_on;
          wr_idx <= copy_rd;
          if (copy_on) begin
            if (copy_rd == LAST_WORD) begin
              copy_on <= 1'b0;
            end else begin
              copy_rd <= copy_rd + 1'b1;
            end
          end
          if (wr_vld && wr_idx == LAST_WORD) begin
            out_valid <= 1'b1;
            state     <= S_OUT;
          end
        end

        S_TRD: begin
          state <= S_TWAIT;
        end

        S_TWAIT: begin
          o_status  <= ST_OK;
          o_word    <= pay_q & word_mask;
          o_len     <= m_len[6:0];
          o_last    <= rem <= 8'd8;
          out_valid <= 1'b1;
          state     <= S_OUT;
        end

        S_OUT: begin
          if (m_acc) begin
            out_valid <= 1'b0;
            if (cmd_r == CMD_TAKE && !o_last) begin
              rd_k  <= rd_k + 1'b1;
              rem   <= rem - 8'd8;
              state <= S_TRD;
            end else begin
              state <= S_IDLE;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_no_accept_while_pending: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid) else $error("input taken while result pending");
  a_error_is_single: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[2:0] != ST_OK) |-> m_tlast) else $error("error result not last");
  a_word_only_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[66:3] != 64'd0) |-> (m_tdata[2:0] == ST_OK))
    else $error("payload word on failed result");
  a_check_in_scan: assert property (@(posedge clk) disable iff (rst)
    chk_vld |-> (state == S_SCAN)) else $error("scan check outside scan");
`endif

endmodule

[hdl/kmbx_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module kmbx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[verif/testbench.sv]
// Self-checking testbench for the keyed mailbox with expiry.
module testbench
  import kmbx_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOTS = 16;
  localparam int NWORDS = 8;
  localparam int STALL_LIMIT = 5000;
  localparam int N_RANDOM = 180;
  localparam int DRAIN_CYCLES = 80;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] word;
    logic [6:0]  len;
    logic [4:0]  count;
    logic        last;
  } mbx_result_t;

  typedef struct {
    logic [2:0]  cmd;
    logic [47:0] mac;
    logic [2:0]  widx;
    logic [63:0] data;
    logic [7:0]  plen;
    logic [63:0] epoch;
    bit          has_result;
    logic [2:0]  want_status;
  } mbx_cmd_t;

  logic         clk;
  logic         rst;
  logic         ttl_we;
  logic [31:0]  ttl_wdata;
  logic         s_tvalid;
  logic         s_tready;
  logic [191:0] s_tdata;
  logic [2:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [79:0]  m_tdata;
  logic         m_tlast;

  // Shadow copy of the mailbox state
  logic [31:0] ttl_q;
  bit          used_q [NSLOTS];
  logic [47:0] key_q [NSLOTS];
  logic [63:0] expiry_q [NSLOTS];
  logic [7:0]  length_q [NSLOTS];
  logic [63:0] payload_q [NSLOTS][NWORDS];
  logic [63:0] staging_q [NWORDS];
  logic [63:0] epoch_q;

  mbx_result_t pending_results[$];
  logic [47:0] known_macs[$];
  int          errors = 0;
  int          idle_cycles = 0;
  int          send_gap_pct = 22;
  int          recv_gap_pct = 65;
  bit          hold_recv = 0;

  keyed_mailbox_with_expiry u_dut (
    .clk(clk), .rst(rst), .ttl_we(ttl_we), .ttl_wdata(ttl_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic mbx_result_t mk_result(logic [2:0] st, logic [63:0] w, logic [6:0] l,
                                            logic [4:0] c, logic lst);
    mbx_result_t r;
    r.status = st;
    r.word = w;
    r.len = l;
    r.count = c;
    r.last = lst;
    return r;
  endfunction

  function automatic int lookup_slot(logic [47:0] mac);
    for (int i = 0; i < NSLOTS; i++)
      if (used_q[i] && key_q[i] == mac) return i;
    return -1;
  endfunction

  // Advance the shadow state and queue the results of one command
  function automatic void predict_mailbox(mbx_cmd_t c);
    int s;
    int nw;
    int rem;
    logic [4:0] cnt;
    logic [63:0] w;
    case (c.cmd)
      CMD_SET_EPOCH: begin
        epoch_q = c.epoch;
        pending_results.push_back(mk_result(ST_OK, 0, 0, 0, 1));
      end
      CMD_LOAD_WORD: begin
        if (c.widx < NWORDS) staging_q[c.widx] = c.data;
        pending_results.push_back(mk_result(ST_OK, 0, 0, 0, 1));
      end
      CMD_PUT: begin
        if (c.plen > NWORDS * 8) begin
          pending_results.push_back(mk_result(ST_INVALID_SIZE, 0, 0, 0, 1));
        end else begin
          s = lookup_slot(c.mac);
          if (s < 0)
            for (int i = 0; i < NSLOTS; i++)
              if (!used_q[i]) begin
                s = i;
                break;
              end
          if (s < 0) begin
            pending_results.push_back(mk_result(ST_FULL, 0, 0, 0, 1));
          end else begin
            for (int k = 0; k < NWORDS; k++) payload_q[s][k] = staging_q[k];
            key_q[s] = c.mac;
            length_q[s] = c.plen;
            expiry_q[s] = epoch_q + {32'd0, ttl_q};
            used_q[s] = 1;
            pending_results.push_back(mk_result(ST_OK, 0, 0, 0, 1));
          end
        end
      end
      CMD_TAKE: begin
        s = lookup_slot(c.mac);
        if (s < 0) begin
          pending_results.push_back(mk_result(ST_NOT_FOUND, 0, 0, 0, 1));
        end else begin
          used_q[s] = 0;
          if (epoch_q != 0 && expiry_q[s] < epoch_q) begin
            pending_results.push_back(mk_result(ST_EXPIRED, 0, 0, 0, 1));
          end else if (length_q[s] == 0) begin
            pending_results.push_back(mk_result(ST_OK, 0, 0, 0, 1));
          end else begin
            nw = (length_q[s] + 7) / 8;
            for (int k = 0; k < nw; k++) begin
              w = payload_q[s][k];
              rem = length_q[s] - k * 8;
              if (rem < 8) w &= (64'd1 << (rem * 8)) - 64'd1;
              pending_results.push_back(mk_result(ST_OK, w, length_q[s][6:0], 0,
                                                  k == nw - 1));
            end
          end
        end
      end
      CMD_PURGE: begin
        cnt = 0;
        for (int i = 0; i < NSLOTS; i++)
          if (used_q[i] && expiry_q[i] < c.epoch) begin
            used_q[i] = 0;
            if (cnt < COUNT_MAX) cnt++;
          end
        pending_results.push_back(mk_result(ST_OK, 0, 0, cnt, 1));
      end
      default: ;
    endcase
  endfunction

  // Drive one transaction and wait for its acceptance
  task automatic send_cmd(mbx_cmd_t c);
    int depth;
    while ($urandom_range(99) < send_gap_pct) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= c.cmd;
    s_tdata <= {5'd0, c.epoch, c.plen, c.data, c.widx, c.mac};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    depth = pending_results.size();
    predict_mailbox(c);
    if (c.has_result && pending_results.size() > depth &&
        pending_results[depth].status != c.want_status) begin
      $error("directed status: expected %0d, predicted %0d", c.want_status,
             pending_results[depth].status);
      errors++;
    end
    @(negedge clk);
  endtask

  task automatic wait_idle();
    s_tvalid <= 0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_ttl(logic [31:0] v);
    ttl_we <= 1;
    ttl_wdata <= v;
    @(negedge clk);
    ttl_we <= 0;
    ttl_q = v;
  endtask

  function automatic mbx_cmd_t make_cmd(logic [2:0] op, logic [47:0] mac, logic [2:0] wi,
                                        logic [63:0] d, logic [7:0] pl, logic [63:0] ep);
    mbx_cmd_t c;
    c.cmd = op;
    c.mac = mac;
    c.widx = wi;
    c.data = d;
    c.plen = pl;
    c.epoch = ep;
    c.has_result = 0;
    c.want_status = ST_OK;
    return c;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [47:0] pick_mac();
    if (known_macs.size() != 0 && $urandom_range(3) != 0)
      return known_macs[$urandom_range(known_macs.size() - 1)];
    return 48'(rand64());
  endfunction

  // Random item: mostly staged puts and takes on a small pool of keys
  function automatic mbx_cmd_t random_cmd();
    int r;
    r = $urandom_range(99);
    if (r < 30)
      return make_cmd(CMD_LOAD_WORD, 48'(rand64()), 3'($urandom), rand64(), 8'($urandom),
                      rand64());
    if (r < 55)
      return make_cmd(CMD_PUT, pick_mac(), 3'($urandom), rand64(),
                      8'(($urandom_range(9) == 0) ? $urandom : $urandom_range(64)),
                      rand64());
    if (r < 80)
      return make_cmd(CMD_TAKE, pick_mac(), 3'($urandom), rand64(), 8'($urandom),
                      rand64());
    if (r < 88)
      return make_cmd(CMD_SET_EPOCH, 48'($urandom), 3'($urandom), rand64(), 8'($urandom),
                      ($urandom_range(3) == 0) ? rand64() : 64'($urandom_range(2000)));
    if (r < 95)
      return make_cmd(CMD_PURGE, 48'($urandom), 3'($urandom), rand64(), 8'($urandom),
                      ($urandom_range(3) == 0) ? rand64() : 64'($urandom_range(2000)));
    return make_cmd(3'($urandom_range(7, 5)), 48'(rand64()), 3'($urandom), rand64(),
                    8'($urandom), rand64());
  endfunction

  // Receiver: random stalls plus the long hold-off
  always @(negedge clk) begin
    if (rst || hold_recv) m_tready <= 0;
    else m_tready <= ($urandom_range(99) >= recv_gap_pct);
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    mbx_result_t got;
    mbx_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = mk_result(m_tdata[2:0], m_tdata[66:3], m_tdata[73:67], m_tdata[78:74], m_tlast);
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction: %h", m_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, got.status); errors++;
        end
        if (got.word !== want.word) begin
          $error("out_word: expected %h, actual %h", want.word, got.word); errors++;
        end
        if (got.len !== want.len) begin
          $error("out_len: expected %0d, actual %0d", want.len, got.len); errors++;
        end
        if (got.count !== want.count) begin
          $error("purged_count: expected %0d, actual %0d", want.count, got.count); errors++;
        end
        if (got.last !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, got.last); errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  mbx_cmd_t directed[$];

  initial begin
    mbx_cmd_t c;
    rst = 1;
    ttl_we = 0;
    ttl_wdata = 0;
    s_tvalid = 0;
    s_tdata = 0;
    s_tuser = 0;
    m_tready = 0;
    ttl_q = TTL_RESET;
    epoch_q = 0;
    for (int i = 0; i < NSLOTS; i++) used_q[i] = 0;
    for (int k = 0; k < NWORDS; k++) staging_q[k] = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed table; status typed in where obvious
    directed.push_back(make_cmd(CMD_TAKE, 48'h0, 0, 0, 0, 0));
    directed[$].has_result = 1; directed[$].want_status = ST_NOT_FOUND;
    directed.push_back(make_cmd(CMD_PUT, 48'hFFFF_FFFF_FFFF, 0, 0, 8'd0, 0)); // zero length
    directed.push_back(make_cmd(CMD_TAKE, 48'hFFFF_FFFF_FFFF, 0, 0, 0, 0));
    directed.push_back(make_cmd(CMD_PUT, 48'h1, 0, 0, 8'd65, 0));
    directed[$].has_result = 1; directed[$].want_status = ST_INVALID_SIZE;
    directed.push_back(make_cmd(CMD_PUT, 48'h1, 0, 0, 8'd255, 0));
    directed[$].has_result = 1; directed[$].want_status = ST_INVALID_SIZE;
    for (int k = 0; k < NWORDS; k++)
      directed.push_back(make_cmd(CMD_LOAD_WORD, 0, 3'(k),
                                  (k % 2) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0123_4567_89AB_CDEF,
                                  0, 0));
    directed.push_back(make_cmd(CMD_PUT, 48'hA5, 7, 0, 8'd64, 0));
    directed.push_back(make_cmd(CMD_PUT, 48'hA5, 0, 0, 8'd13, 0)); // overwrite, partial word
    directed.push_back(make_cmd(CMD_TAKE, 48'hA5, 0, 0, 0, 0));
    directed.push_back(make_cmd(CMD_PUT, 48'hB6, 0, 0, 8'd64, 0));
    directed.push_back(make_cmd(CMD_SET_EPOCH, 0, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF));
    directed.push_back(make_cmd(CMD_TAKE, 48'hB6, 0, 0, 0, 0));
    directed[$].has_result = 1; directed[$].want_status = ST_EXPIRED;
    directed.push_back(make_cmd(CMD_PUT, 48'hC7, 0, 0, 8'd8, 0)); // expiry wraps
    directed.push_back(make_cmd(CMD_PURGE, 0, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF));
    directed.push_back(make_cmd(3'd7, 48'hC7, 0, 0, 0, 0)); // unknown command
    directed.push_back(make_cmd(CMD_SET_EPOCH, 0, 0, 0, 0, 64'd0));
    foreach (directed[i]) send_cmd(directed[i]);
    wait_idle();

    // Fill the table: full, then purge of all sixteen
    write_ttl(32'd0);
    for (int i = 0; i <= NSLOTS; i++)
      send_cmd(make_cmd(CMD_PUT, 48'(i + 1000), 0, 0, 8'd16, 0));
    send_cmd(make_cmd(CMD_PURGE, 0, 0, 0, 0, 64'd1));
    wait_idle();

    // Random phases with changing lifetime and idle patterns
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_ttl(32'hFFFF_FFFF);
        1: begin write_ttl(32'd50); send_gap_pct = 65; recv_gap_pct = 22; end
        2: begin write_ttl($urandom); send_gap_pct = 0; recv_gap_pct = 0; end
        default: write_ttl(32'd300);
      endcase
      known_macs.delete();
      for (int i = 0; i < 6; i++) known_macs.push_back(48'(rand64()));
      if (ph == 2) fork
        begin
          hold_recv = 1;
          repeat (300) @(negedge clk);
          hold_recv = 0;
        end
      join_none
      for (int n = 0; n < N_RANDOM / 4; n++) begin
        c = random_cmd();
        send_cmd(c);
      end
      wait_idle();
    end

    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
